/* src/servo_status_packet_receiver_assert.svh */
// assertion macros used by the checker file
`ifndef SERVO_STATUS_PACKET_RECEIVER_ASSERT_SVH
`define SERVO_STATUS_PACKET_RECEIVER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SSPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sspr assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SSPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sspr assertion failed");

`endif

/* src/sspr_pkg.sv */
// shared types and constants of the servo status packet receiver
package sspr_pkg;

    localparam int MAX_PACKET   = 32;
    localparam int CNT_W        = $clog2(MAX_PACKET + 1);
    localparam int TOTAL_W      = 9;
    localparam int BYTE_INDEX_W = 5;
    localparam int TICKS_W      = 16;

    localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [7:0]         SUM_GOOD      = 8'hFF;
    localparam logic [7:0]         LEN_OVERHEAD  = 8'd4;
    localparam logic [7:0]         LEN_MIN       = 8'd2;
    localparam logic [CNT_W-1:0]   IDX_SUM_FIRST = CNT_W'(2);
    localparam logic [CNT_W-1:0]   IDX_LENGTH    = CNT_W'(3);

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_TICK  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_BUSY     = 3'd0,
        ST_GOOD     = 3'd1,
        ST_CHECKSUM = 3'd2,
        ST_TIMEOUT  = 3'd3,
        ST_LENGTH   = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [BYTE_INDEX_W-1:0] byte_index;
        logic [7:0]              packet_byte;
        logic [2:0]              status;
        logic                    last;
    } t_result;

endpackage

/* src/sspr_in_stage.sv */
// input register holding one accepted item
module sspr_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  sspr_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_ready,
    output logic           o_valid,
    output sspr_pkg::t_item o_item
);

    logic            r_valid;
    sspr_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* src/sspr_core.sv */
// packet state, checksum, length check and tick countdown
module sspr_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sspr_pkg::TICKS_W-1:0]   i_cfg_ticks,
    input  logic                           i_fire,
    input  sspr_pkg::t_item                i_item,
    output logic                           o_res_valid,
    output sspr_pkg::t_result              o_res
);

    logic [sspr_pkg::TICKS_W-1:0] r_ticks;
    logic                         r_receiving, n_receiving;
    logic [sspr_pkg::CNT_W-1:0]   r_count, n_count;
    logic [sspr_pkg::CNT_W-1:0]   r_exp, n_exp;
    logic [7:0]                   r_sum, n_sum;
    logic [sspr_pkg::TICKS_W-1:0] r_left, n_left;

    logic [sspr_pkg::TOTAL_W-1:0] total;
    logic [sspr_pkg::CNT_W-1:0]   count_inc;
    logic                         len_bad;

    assign total     = sspr_pkg::TOTAL_W'(i_item.rx_byte)
                     + sspr_pkg::TOTAL_W'(sspr_pkg::LEN_OVERHEAD);
    assign count_inc = r_count + sspr_pkg::CNT_W'(1);
    assign len_bad   = (i_item.rx_byte < sspr_pkg::LEN_MIN)
                    || (total > sspr_pkg::TOTAL_W'(sspr_pkg::MAX_PACKET));

    always_comb begin
        n_receiving = r_receiving;
        n_count     = r_count;
        n_exp       = r_exp;
        n_sum       = r_sum;
        n_left      = r_left;
        o_res_valid = 1'b0;
        o_res.byte_index  = r_count[sspr_pkg::BYTE_INDEX_W-1:0];
        o_res.packet_byte = i_item.rx_byte;
        o_res.status      = sspr_pkg::ST_BUSY;
        o_res.last        = 1'b0;
        case (i_item.action)
            sspr_pkg::ACT_START: begin
                n_receiving = 1'b1;
                n_count     = '0;
                n_exp       = '0;
                n_sum       = '0;
                n_left      = r_ticks;
            end
            sspr_pkg::ACT_TICK: begin
                if (r_receiving) begin
                    if (r_left <= sspr_pkg::TICKS_W'(1)) begin
                        n_left            = '0;
                        n_receiving       = 1'b0;
                        o_res_valid       = 1'b1;
                        o_res.packet_byte = '0;
                        o_res.status      = sspr_pkg::ST_TIMEOUT;
                        o_res.last        = 1'b1;
                    end else begin
                        n_left = r_left - sspr_pkg::TICKS_W'(1);
                    end
                end
            end
            sspr_pkg::ACT_BYTE: begin
                if (r_receiving) begin
                    o_res_valid = 1'b1;
                    if (r_count >= sspr_pkg::IDX_SUM_FIRST) begin
                        n_sum = r_sum + i_item.rx_byte;
                    end
                    if (r_count == sspr_pkg::IDX_LENGTH && len_bad) begin
                        n_receiving  = 1'b0;
                        o_res.status = sspr_pkg::ST_LENGTH;
                        o_res.last   = 1'b1;
                    end else begin
                        if (r_count == sspr_pkg::IDX_LENGTH) begin
                            n_exp = total[sspr_pkg::CNT_W-1:0];
                        end
                        n_count = count_inc;
                        if (r_count >= sspr_pkg::IDX_LENGTH && count_inc >= n_exp) begin
                            n_receiving  = 1'b0;
                            o_res.status = (n_sum == sspr_pkg::SUM_GOOD)
                                         ? sspr_pkg::ST_GOOD : sspr_pkg::ST_CHECKSUM;
                            o_res.last   = 1'b1;
                        end else begin
                            n_left = r_ticks;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks     <= sspr_pkg::TIMEOUT_RESET;
            r_receiving <= 1'b0;
            r_count     <= '0;
            r_exp       <= '0;
            r_sum       <= '0;
            r_left      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_ticks <= i_cfg_ticks;
            end
            if (i_fire) begin
                r_receiving <= n_receiving;
                r_count     <= n_count;
                r_exp       <= n_exp;
                r_sum       <= n_sum;
                r_left      <= n_left;
            end
        end
    end

endmodule

/* src/sspr_out_stage.sv */
// result register toward the output channel
module sspr_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sspr_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_can_load,
    output logic              o_valid,
    output sspr_pkg::t_result o_res
);

    logic              r_valid;
    sspr_pkg::t_result r_res;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

/* src/servo_status_packet_receiver.sv */
// top level of the servo status packet receiver
//
//  channel | direction | handshake                  | payload
//  in      | sink      | i_in_valid / o_in_ready    | i_action, i_rx_byte
//  out     | source    | o_out_valid / i_out_ready  | o_byte_index, o_packet_byte,
//          |           |                            | o_status, o_last
//  cfg     | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_timeout_ticks
//
// one transaction per cycle on the input while o_in_ready is high; each item is
// held in the input register, then its result goes into the result register
// reset is synchronous active low; timeout_ticks returns to 1000, receiver idle
// a stalled output holds its result while the input register still drains into
// the result register as soon as that register is taken
// cfg_ready is always high; the write lands the next edge
module servo_status_packet_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_rx_byte,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_byte_index,
    output logic [7:0]  o_packet_byte,
    output logic [2:0]  o_status,
    output logic        o_last,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_timeout_ticks
);

    sspr_pkg::t_item   in_item;
    sspr_pkg::t_item   held_item;
    sspr_pkg::t_result core_res;
    sspr_pkg::t_result out_res;
    logic              held_valid;
    logic              can_load;
    logic              fire;
    logic              res_valid;

    assign in_item.action  = i_action;
    assign in_item.rx_byte = i_rx_byte;

    // an item leaves the input register when the result slot is free or freeing
    assign fire        = held_valid && can_load;
    assign o_cfg_ready = 1'b1;

    sspr_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .i_take  (fire),
        .o_ready (o_in_ready),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    // packet tracking: counter, checksum, length check, tick countdown
    sspr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_ticks (i_cfg_timeout_ticks),
        .i_fire      (fire),
        .i_item      (held_item),
        .o_res_valid (res_valid),
        .o_res       (core_res)
    );

    // only items that produce a result occupy the result register
    sspr_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire && res_valid),
        .i_res      (core_res),
        .i_ready    (i_out_ready),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .o_res      (out_res)
    );

    assign o_byte_index  = out_res.byte_index;
    assign o_packet_byte = out_res.packet_byte;
    assign o_status      = out_res.status;
    assign o_last        = out_res.last;

endmodule

/* src/sspr_checker.sv */
// port-level checks of the servo status packet receiver and their binding
`include "servo_status_packet_receiver_assert.svh"

module sspr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [4:0]  o_byte_index,
    input logic [7:0]  o_packet_byte,
    input logic [2:0]  o_status,
    input logic        o_last
);

    logic        out_stall;
    logic [16:0] out_payload;
    logic        out_closing;
    logic        timeout_out;
    logic        length_out;
    logic        at_length;

    assign out_stall   = o_out_valid && !i_out_ready;
    assign out_payload = {o_byte_index, o_packet_byte, o_status, o_last};
    assign out_closing = (o_status != sspr_pkg::ST_BUSY);
    assign timeout_out = o_out_valid && (o_status == sspr_pkg::ST_TIMEOUT);
    assign length_out  = o_out_valid && (o_status == sspr_pkg::ST_LENGTH);
    assign at_length   = ({1'b0, o_byte_index} == sspr_pkg::IDX_LENGTH);

    // a stalled result holds
    `SSPR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(out_payload))

    // only an in-progress result leaves the packet open
    `SSPR_ASSERT_NOW(a_last_status, i_clk, i_rst_n, o_out_valid, o_last == out_closing)

    // timeout results carry no byte
    `SSPR_ASSERT_NOW(a_timeout_zero, i_clk, i_rst_n, timeout_out, o_packet_byte == 8'd0)

    // a length error is always reported on the length field
    `SSPR_ASSERT_NOW(a_length_index, i_clk, i_rst_n, length_out, at_length)

endmodule

bind servo_status_packet_receiver sspr_checker u_checker (.*);

/* bench/tb_top.sv */
// testbench top for the servo status packet receiver, with in-bench echo prediction
`timescale 1ns / 100ps

module tb_top;

    // action code the block must ignore
    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam int MAX_REPORTS   = 10;
    // input register plus result register, with some margin
    localparam int SETTLE_CYCLES = 4;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_action;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [4:0]  o_byte_index;
    logic [7:0]  o_packet_byte;
    logic [2:0]  o_status;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_timeout_ticks;

    // predicted receiver state, advanced once per accepted input transaction
    logic        rx_active;
    logic [5:0]  rx_count;
    logic [5:0]  rx_total;
    logic [7:0]  rx_sum;
    logic [15:0] ticks_left;
    logic [15:0] timeout_cfg;

    sspr_pkg::t_result echo_q[$];     // echoes still owed by the block, oldest first
    int      mismatches;
    int      items_sent;
    bit      idle_in;       // random gaps on the input side
    bit      idle_out;      // random stalls on the result side

    servo_status_packet_receiver dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_action            (i_action),
        .i_rx_byte           (i_rx_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_byte_index        (o_byte_index),
        .o_packet_byte       (o_packet_byte),
        .o_status            (o_status),
        .o_last              (o_last),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_timeout_ticks (i_cfg_timeout_ticks)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // echo predictor: returns 1 when the item yields a result
    function automatic bit predict_echo(input logic [1:0] act, input logic [7:0] b,
                                        output sspr_pkg::t_result r);
        logic [5:0] pos;
        logic [8:0] total;
        r = '0;
        if (act == sspr_pkg::ACT_START) begin
            // start always (re)opens a packet, dropping any packet in flight
            rx_active  = 1'b1;
            rx_count   = '0;
            rx_total   = '0;
            rx_sum     = '0;
            ticks_left = timeout_cfg;
            return 1'b0;
        end
        if (!rx_active) return 1'b0;
        if (act == sspr_pkg::ACT_TICK) begin
            // a zero countdown expires on the first tick, same as one
            if (ticks_left <= 16'd1) begin
                ticks_left = '0;
                rx_active  = 1'b0;
                r = '{rx_count[4:0], 8'h00, sspr_pkg::ST_TIMEOUT, 1'b1};
                return 1'b1;
            end
            ticks_left = ticks_left - 16'd1;
            return 1'b0;
        end
        if (act != sspr_pkg::ACT_BYTE) return 1'b0;

        pos = rx_count;
        if (pos >= 6'd2) rx_sum = rx_sum + b;
        if (pos == 6'd3) begin
            // length field: too short or too long for the buffer stops reception
            total = {1'b0, b} + 9'(sspr_pkg::LEN_OVERHEAD);
            if (b < sspr_pkg::LEN_MIN || total > 9'(sspr_pkg::MAX_PACKET)) begin
                rx_active = 1'b0;
                r = '{pos[4:0], b, sspr_pkg::ST_LENGTH, 1'b1};
                return 1'b1;
            end
            rx_total = total[5:0];
        end
        rx_count = pos + 6'd1;
        if (pos >= 6'd3 && rx_count >= rx_total) begin
            rx_active = 1'b0;
            r = '{pos[4:0], b,
                  (rx_sum == sspr_pkg::SUM_GOOD) ? sspr_pkg::ST_GOOD : sspr_pkg::ST_CHECKSUM,
                  1'b1};
            return 1'b1;
        end
        // every byte that keeps the packet open reloads the countdown
        ticks_left = timeout_cfg;
        r = '{pos[4:0], b, sspr_pkg::ST_BUSY, 1'b0};
        return 1'b1;
    endfunction

    // result side: draw a stall before each transaction, then hold ready until one lands
    initial begin : out_stall
        int gap;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = idle_out ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // compare each accepted result with the oldest predicted echo
    always @(posedge i_clk) begin : check_echo
        sspr_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (echo_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result idx=%0d byte=%h status=%0d last=%0b",
                             $time, o_byte_index, o_packet_byte, o_status, o_last);
            end else begin
                want = echo_q.pop_front();
                if (o_byte_index !== want.byte_index || o_packet_byte !== want.packet_byte ||
                    o_status !== want.status || o_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: expected idx=%0d byte=%h status=%0d last=%0b, got %s",
                                 $time, want.byte_index, want.packet_byte, want.status,
                                 want.last, $sformatf("idx=%0d byte=%h status=%0d last=%0b",
                                 o_byte_index, o_packet_byte, o_status, o_last));
                end
            end
        end
    end

    // one input transaction, preceded by a random gap when input idling is on
    task automatic send_item(input logic [1:0] act, input logic [7:0] b);
        int                gap;
        sspr_pkg::t_result r;
        gap = idle_in ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        if (predict_echo(act, b, r)) echo_q.push_back(r);
        items_sent++;
    endtask

    // drain: wait until all echoes are in, then let items that give no result settle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (echo_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [15:0] ticks);
        settle();
        i_cfg_valid         <= 1'b1;
        i_cfg_timeout_ticks <= ticks;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        timeout_cfg = ticks;
    endtask

    // start plus one status packet: header, id, length field, parameters, checksum
    // ticks are interleaved below the countdown unless a timeout is forced;
    // cut stops the packet early so the next start lands mid-packet
    task automatic send_packet(input logic [7:0] len_field, input bit good_sum,
                               input int cut, input bit force_timeout);
        logic [7:0] pkt[32];
        logic [7:0] sum;
        int n, eff, wait_max, late_at, k;
        eff      = (timeout_cfg == 16'd0) ? 1 : int'(timeout_cfg);
        wait_max = (eff - 1 < 4) ? eff - 1 : 4;
        n = (len_field >= sspr_pkg::LEN_MIN &&
             int'(len_field) + int'(sspr_pkg::LEN_OVERHEAD) <= sspr_pkg::MAX_PACKET) ?
            int'(len_field) + int'(sspr_pkg::LEN_OVERHEAD) : 4;
        late_at = (force_timeout && eff <= 8) ? $urandom_range(0, n - 1) : -1;
        pkt[0] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'hFF;
        pkt[1] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'hFF;
        pkt[2] = 8'($urandom);
        pkt[3] = len_field;
        sum = pkt[2] + pkt[3];
        for (int i = 4; i < n - 1; i++) begin
            pkt[i] = 8'($urandom);
            sum = sum + pkt[i];
        end
        if (n > 4)
            pkt[n-1] = good_sum ? 8'hFF - sum : 8'hFF - sum + 8'($urandom_range(1, 255));
        send_item(sspr_pkg::ACT_START, 8'($urandom));
        for (int i = 0; i < n && i < cut; i++) begin
            k = (i == late_at) ? eff : $urandom_range(0, wait_max);
            repeat (k) send_item(sspr_pkg::ACT_TICK, 8'($urandom));
            send_item(sspr_pkg::ACT_BYTE, pkt[i]);
        end
    endtask

    // reset countdown of 1000: 999 ticks pass, the 1000th ends the packet
    task automatic test_reset_timeout();
        idle_in  = 1'b0;
        idle_out = 1'b0;
        send_item(sspr_pkg::ACT_START, 8'h00);
        repeat (1000) send_item(sspr_pkg::ACT_TICK, 8'hFF);
        settle();
    endtask

    task automatic test_packet_endings();
        logic [7:0] good_pkt[6];
        idle_in  = 1'b1;
        idle_out = 1'b1;
        write_timeout(16'd5);
        // shortest packet with a good checksum, then the same with a bad one
        good_pkt = '{8'hFF, 8'hFF, 8'h01, 8'h02, 8'h00, 8'hFC};
        send_item(sspr_pkg::ACT_START, 8'h00);
        foreach (good_pkt[i]) send_item(sspr_pkg::ACT_BYTE, good_pkt[i]);
        send_item(sspr_pkg::ACT_START, 8'h00);
        foreach (good_pkt[i]) send_item(sspr_pkg::ACT_BYTE, (i == 5) ? 8'h00 : good_pkt[i]);
        // longest packet the buffer holds
        send_packet(8'd28, 1'b1, 99, 1'b0);
        send_packet(8'd28, 1'b0, 99, 1'b0);
        settle();
    endtask

    task automatic test_length_errors();
        // length field below two, just over the buffer, and the largest byte
        send_packet(8'd0, 1'b1, 99, 1'b0);
        send_packet(8'd1, 1'b1, 99, 1'b0);
        send_packet(8'd29, 1'b1, 99, 1'b0);
        send_packet(8'd255, 1'b1, 99, 1'b0);
        // bytes after a length error are ignored
        send_item(sspr_pkg::ACT_BYTE, 8'h55);
        settle();
    endtask

    task automatic test_ignored_items();
        // idle receiver drops bytes, ticks and the reserved action
        send_item(sspr_pkg::ACT_BYTE, 8'hA5);
        send_item(sspr_pkg::ACT_TICK, 8'h5A);
        send_item(ACT_RESERVED, 8'hFF);
        // reserved action mid-packet, then a restart that drops the packet in flight
        send_item(sspr_pkg::ACT_START, 8'h00);
        send_item(sspr_pkg::ACT_BYTE, 8'hFF);
        send_item(ACT_RESERVED, 8'h00);
        send_item(sspr_pkg::ACT_BYTE, 8'hFF);
        send_packet(8'd3, 1'b1, 99, 1'b0);
        settle();
    endtask

    task automatic test_timeouts();
        // a byte reloads the countdown
        write_timeout(16'd3);
        send_item(sspr_pkg::ACT_START, 8'h00);
        repeat (2) send_item(sspr_pkg::ACT_TICK, 8'h00);
        send_item(sspr_pkg::ACT_BYTE, 8'hFF);
        repeat (3) send_item(sspr_pkg::ACT_TICK, 8'h00);
        // zero acts as one
        write_timeout(16'd0);
        send_item(sspr_pkg::ACT_START, 8'h00);
        send_item(sspr_pkg::ACT_TICK, 8'h00);
        write_timeout(16'd1);
        send_item(sspr_pkg::ACT_START, 8'h00);
        send_item(sspr_pkg::ACT_BYTE, 8'hFF);
        send_item(sspr_pkg::ACT_TICK, 8'h00);
        // widest countdown never expires within a packet
        write_timeout(16'hFFFF);
        send_packet(8'd4, 1'b1, 99, 1'b0);
        settle();
    endtask

    // mostly well-formed packets with random content, some noise and broken packets
    task automatic test_random_traffic(input logic [15:0] ticks, input int items);
        int stop;
        logic [7:0] len;
        write_timeout(ticks);
        stop = items_sent + items;
        while (items_sent < stop) begin
            // per-packet idling so some stretches run back to back
            idle_in  = ($urandom_range(0, 3) != 0);
            idle_out = ($urandom_range(0, 3) != 0);
            len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(2, 28)) :
                                                 8'($urandom_range(2, 6));
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 4)) send_item(2'($urandom), 8'($urandom));
                1: send_packet(8'($urandom), 1'b1, 99, 1'b0);
                2: send_packet(len, 1'b1, $urandom_range(0, 30), 1'b0);
                3: send_packet(len, 1'b1, 99, 1'b1);
                default: send_packet(len, ($urandom_range(0, 3) != 0), 99, 1'b0);
            endcase
        end
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        i_in_valid          <= 1'b0;
        i_action            <= sspr_pkg::ACT_START;
        i_rx_byte           <= 8'h00;
        i_cfg_valid         <= 1'b0;
        i_cfg_timeout_ticks <= sspr_pkg::TIMEOUT_RESET;
        rx_active   = 1'b0;
        rx_count    = '0;
        rx_total    = '0;
        rx_sum      = '0;
        ticks_left  = '0;
        timeout_cfg = sspr_pkg::TIMEOUT_RESET;
        mismatches  = 0;
        items_sent  = 0;
        idle_in     = 1'b1;
        idle_out    = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_timeout();
        test_packet_endings();
        test_length_errors();
        test_ignored_items();
        test_timeouts();
        test_random_traffic(16'd1, 20);
        test_random_traffic(16'd2, 20);
        test_random_traffic(16'd4, 20);
        test_random_traffic(16'($urandom_range(3, 12)), 20);
        test_random_traffic(16'hFFFF, 20);
        settle();

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
